// File: hdl/pc_pkg.sv
// ----------------------------------------------------------------------------
// pc_pkg
// Shared widths, status codes and controller/datapath interface types for the
// shoelace polygon centroid core.
// ----------------------------------------------------------------------------
package pc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int MAX_VERTICES = 256;

    // vertex count saturates at MAX_VERTICES+1
    localparam int CNT_W   = $clog2(MAX_VERTICES + 2);
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int A_W     = PROD_W + 1;
    localparam int SUM_W   = COORD_BITS + 1;
    localparam int MX_W    = SUM_W + A_W;
    localparam int AREA_W  = A_W + $clog2(MAX_VERTICES + 1);
    localparam int MOM_W   = MX_W + $clog2(MAX_VERTICES + 1) + 1;
    localparam int DEN_W   = AREA_W + 2;
    localparam int OUT_W   = 16;

    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 2 * OUT_W;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_AREA = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    localparam int ST_W = $bits(t_status);

    typedef struct packed {
        logic    load;       // capture the accepted vertex
        logic    sel_close;  // edge operands: previous vertex to first vertex
        logic    acc_area;
        logic    acc_mom;
        logic    den_load;   // register 3*area_sum
        logic    div_start;
        logic    div_sel_y;
        logic    cap_x;
        logic    cap_y;
        logic    res_wr;     // write status, clear centroids
        t_status res_st;
        logic    emit;       // hand result to output, clear polygon state
    } t_dp_cmd;

    typedef struct packed {
        logic do_edge;
        logic last;
        logic over;
        logic area_zero;
        logic div_done;
    } t_dp_stat;

endpackage

// File: hdl/pc_div.sv
// ----------------------------------------------------------------------------
// pc_div
// Restoring signed divider, one quotient bit per cycle. Quotient truncates
// toward zero and is saturated to the 16-bit signed output range.
// ----------------------------------------------------------------------------
module pc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [pc_pkg::MOM_W-1:0]     i_num,
    input  logic signed [pc_pkg::DEN_W-1:0]     i_den,
    output logic                                o_done,
    output logic signed [pc_pkg::OUT_W-1:0]     o_quo
);
    import pc_pkg::*;

    localparam int STEP_W = $clog2(MOM_W + 1);

    logic [MOM_W-1:0]  r_quo;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_div;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;

    logic [MOM_W-1:0]  num_mag;
    logic [DEN_W-1:0]  den_mag;
    logic [DEN_W:0]    trial;
    logic              fits;

    always_comb begin
        num_mag = i_num[MOM_W-1] ? MOM_W'(-i_num) : MOM_W'(i_num);
        den_mag = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        trial   = {r_rem, r_quo[MOM_W-1]};
        fits    = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(MOM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= num_mag;
            r_rem <= '0;
            r_div <= den_mag;
            r_neg <= i_num[MOM_W-1] ^ i_den[DEN_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[MOM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_div}) : trial[DEN_W-1:0];
        end
    end

    // saturate magnitude and apply sign
    always_comb begin
        if (r_neg) begin
            if (r_quo > MOM_W'(2 ** (OUT_W - 1)))
                o_quo = {1'b1, {(OUT_W - 1){1'b0}}};
            else
                o_quo = -(r_quo[OUT_W-1:0]);
        end else begin
            if (r_quo > MOM_W'(2 ** (OUT_W - 1) - 1))
                o_quo = {1'b0, {(OUT_W - 1){1'b1}}};
            else
                o_quo = r_quo[OUT_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// File: hdl/pc_dpath.sv
// ----------------------------------------------------------------------------
// pc_dpath
// Edge pipeline (cross product, moment products), polygon accumulators,
// vertex bookkeeping and the shared divider for both centroid axes.
// ----------------------------------------------------------------------------
module pc_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [pc_pkg::COORD_BITS-1:0] i_vx,
    input  logic signed [pc_pkg::COORD_BITS-1:0] i_vy,
    input  logic                                 i_last,
    input  pc_pkg::t_dp_cmd                      i_cmd,
    output pc_pkg::t_dp_stat                     o_stat,
    output logic signed [pc_pkg::OUT_W-1:0]      o_cx,
    output logic signed [pc_pkg::OUT_W-1:0]      o_cy,
    output pc_pkg::t_status                      o_st
);
    import pc_pkg::*;

    // polygon state
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [CNT_W-1:0]             r_count;
    logic signed [AREA_W-1:0]     r_area;
    logic signed [MOM_W-1:0]      r_mom_x, r_mom_y;
    logic                         r_do_edge, r_last, r_over;

    // edge pipeline
    logic signed [PROD_W-1:0]     r_p0, r_p1;
    logic signed [SUM_W-1:0]      r_sx1, r_sy1, r_sx2, r_sy2;
    logic signed [A_W-1:0]        r_a;
    logic signed [MX_W-1:0]       r_mx, r_my;

    logic signed [DEN_W-1:0]      r_den;
    logic signed [OUT_W-1:0]      r_cx, r_cy;
    t_status                      r_st;

    logic signed [COORD_BITS-1:0] x1, y1;
    logic                         fresh, in_range;
    logic                         div_done;
    logic signed [OUT_W-1:0]      div_quo;

    always_comb begin
        x1       = i_cmd.sel_close ? r_first_x : i_vx;
        y1       = i_cmd.sel_close ? r_first_y : i_vy;
        fresh    = (r_count == '0);
        in_range = (r_count < CNT_W'(MAX_VERTICES));
    end

    // free-running edge pipeline, accumulation is commanded
    always_ff @(posedge i_clk) begin
        r_p0  <= r_prev_x * y1;
        r_p1  <= x1 * r_prev_y;
        r_sx1 <= SUM_W'(r_prev_x) + SUM_W'(x1);
        r_sy1 <= SUM_W'(r_prev_y) + SUM_W'(y1);
        r_a   <= A_W'(r_p0) - A_W'(r_p1);
        r_sx2 <= r_sx1;
        r_sy2 <= r_sy1;
        r_mx  <= r_sx2 * r_a;
        r_my  <= r_sy2 * r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_count   <= '0;
            r_area    <= '0;
            r_mom_x   <= '0;
            r_mom_y   <= '0;
            r_do_edge <= 1'b0;
            r_last    <= 1'b0;
            r_over    <= 1'b0;
        end else if (i_cmd.emit) begin
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_count   <= '0;
            r_area    <= '0;
            r_mom_x   <= '0;
            r_mom_y   <= '0;
            r_do_edge <= 1'b0;
            r_last    <= 1'b0;
            r_over    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_count <= CNT_W'(MAX_VERTICES))
                    r_count <= r_count + CNT_W'(1);
                if (in_range) begin
                    if (fresh) begin
                        r_first_x <= i_vx;
                        r_first_y <= i_vy;
                    end
                    r_prev_x <= i_vx;
                    r_prev_y <= i_vy;
                end
                r_do_edge <= in_range && !fresh;
                r_last    <= i_last;
                r_over    <= !in_range;
            end
            if (i_cmd.acc_area)
                r_area <= r_area + AREA_W'(r_a);
            if (i_cmd.acc_mom) begin
                r_mom_x <= r_mom_x + MOM_W'(r_mx);
                r_mom_y <= r_mom_y + MOM_W'(r_my);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.den_load)
            r_den <= DEN_W'(r_area) + (DEN_W'(r_area) <<< 1);
        if (i_cmd.res_wr) begin
            r_st <= i_cmd.res_st;
            r_cx <= '0;
            r_cy <= '0;
        end
        if (i_cmd.cap_x)
            r_cx <= div_quo;
        if (i_cmd.cap_y)
            r_cy <= div_quo;
    end

    pc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (i_cmd.div_sel_y ? r_mom_y : r_mom_x),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        o_stat.do_edge   = r_do_edge;
        o_stat.last      = r_last;
        o_stat.over      = r_over;
        o_stat.area_zero = (r_area == '0);
        o_stat.div_done  = div_done;
    end

    assign o_cx = r_cx;
    assign o_cy = r_cy;
    assign o_st = r_st;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_VERTICES + 1))
        else $error("vertex count beyond saturation value");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_count == '0) && (r_area == '0) && (r_mom_x == '0))
        else $error("polygon state not cleared after result");

endmodule

// File: hdl/pc_ctrl.sv
// ----------------------------------------------------------------------------
// pc_ctrl
// Sequencer: vertex intake, edge pipeline stepping, closing edge, zero-area
// and overflow checks, the two divisions and result hand-off.
// ----------------------------------------------------------------------------
module pc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_free,
    input  pc_pkg::t_dp_stat i_stat,
    output pc_pkg::t_dp_cmd  o_cmd
);
    import pc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB,
        S_MOM,
        S_ACC,
        S_CLOSE,
        S_CHECK,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_closing, n_closing;

    t_state fin_state;
    logic   fin_over;

    // where to go once the edge of this step is done or skipped
    always_comb begin
        fin_over = 1'b0;
        if (r_closing) begin
            fin_state = S_CHECK;
        end else if (i_stat.last) begin
            if (i_stat.over) begin
                fin_state = S_OUT;
                fin_over  = 1'b1;
            end else begin
                fin_state = S_CLOSE;
            end
        end else begin
            fin_state = S_IDLE;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_closing = r_closing;
        o_cmd     = '0;
        o_cmd.res_st = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SUB;
                end
            end
            S_SUB: begin
                if (i_stat.do_edge || r_closing) begin
                    n_state = S_MOM;
                end else begin
                    n_state      = fin_state;
                    o_cmd.res_wr = fin_over;
                    o_cmd.res_st = ST_OVERFLOW;
                end
            end
            S_MOM: begin
                o_cmd.acc_area = 1'b1;
                n_state        = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_mom = 1'b1;
                n_state       = fin_state;
                o_cmd.res_wr  = fin_over;
                o_cmd.res_st  = ST_OVERFLOW;
            end
            S_CLOSE: begin
                o_cmd.sel_close = 1'b1;
                n_closing       = 1'b1;
                n_state         = S_SUB;
            end
            S_CHECK: begin
                o_cmd.res_wr = 1'b1;
                if (i_stat.area_zero) begin
                    o_cmd.res_st = ST_ZERO_AREA;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.res_st   = ST_OK;
                    o_cmd.den_load = 1'b1;
                    n_state        = S_DIVX_GO;
                end
            end
            S_DIVX_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVX_WAIT;
            end
            S_DIVX_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_x = 1'b1;
                    n_state     = S_DIVY_GO;
                end
            end
            S_DIVY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state         = S_DIVY_WAIT;
            end
            S_DIVY_WAIT: begin
                o_cmd.div_sel_y = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.cap_y = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_closing  = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state   = S_IDLE;
                n_closing = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_closing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_closing <= n_closing;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hdl/polygon_centroid_core.sv
// ----------------------------------------------------------------------------
// polygon_centroid_core
// Shoelace centroid of a polygon streamed one vertex per item; one result per
// polygon, issued after the item marked last.
// ----------------------------------------------------------------------------
// intake: one vertex at a time; the next is taken once the previous one has
//   left the cross product / moment pipeline. the shared divider resolves one
//   quotient bit per cycle over 48 bits, once per axis. zero area or too many
//   vertices skip the divisions
// the output register holds a result while the next polygon streams in
// reset: synchronous, active low; clears polygon state and the output valid
// ----------------------------------------------------------------------------
module polygon_centroid_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pc_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // vertex_x, vertex_y
    input  logic                              s_axis_tlast,   // last_vertex
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // centroid_x, centroid_y
    output logic [pc_pkg::ST_W-1:0]           m_axis_tuser    // status
);
    import pc_pkg::*;

    t_dp_cmd                 cmd;
    t_dp_stat                stat;
    logic signed [OUT_W-1:0] res_cx, res_cy;
    t_status                 res_st;
    logic                    out_free;

    logic                    r_tvalid;
    logic [OUT_DATA_W-1:0]   r_tdata;
    logic [ST_W-1:0]         r_tuser;

    assign out_free = !r_tvalid || m_axis_tready;

    pc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pc_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vx    (s_axis_tdata[COORD_BITS-1:0]),
        .i_vy    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_last  (s_axis_tlast),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_cx    (res_cx),
        .o_cy    (res_cy),
        .o_st    (res_st)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (cmd.emit) begin
            r_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_tdata <= {res_cy, res_cx};
            r_tuser <= ST_W'(res_st);
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input item accepted while previous vertex still in work");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_W'(ST_OK))) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero centroid");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result issued while idle");

endmodule
